// ----- sv/gre_pkg.sv -----
// shared types, constants and codes of the gamepad report encoder
package gre_pkg;

    // physical buttons that go through the usage map
    localparam int PHYS_BUTTONS = 8;

    // register reset values
    localparam logic [31:0] MAP_RESET  = 32'h7865_4321;
    localparam logic [7:0]  HOLD_RESET = 8'd250;

    // stick levels
    localparam logic [7:0] STICK_LOW    = 8'h00;
    localparam logic [7:0] STICK_CENTER = 8'h80;
    localparam logic [7:0] STICK_HIGH   = 8'hFF;

    // usage codes that map to no button bit
    localparam logic [3:0] USAGE_NONE = 4'd0;
    localparam logic [3:0] USAGE_VOID = 4'd15;

    // hat codes
    localparam logic [3:0] HAT_N    = 4'd0;
    localparam logic [3:0] HAT_NE   = 4'd1;
    localparam logic [3:0] HAT_E    = 4'd2;
    localparam logic [3:0] HAT_SE   = 4'd3;
    localparam logic [3:0] HAT_S    = 4'd4;
    localparam logic [3:0] HAT_SW   = 4'd5;
    localparam logic [3:0] HAT_W    = 4'd6;
    localparam logic [3:0] HAT_NW   = 4'd7;
    localparam logic [3:0] HAT_NONE = 4'd8;

    // d-pad modes
    localparam logic [1:0] DPAD_ANALOG = 2'd0;
    localparam logic [1:0] DPAD_HAT    = 2'd1;
    localparam logic [1:0] DPAD_ZRZ    = 2'd2;

    // button bit positions in the sample
    localparam int BTN_L     = 4;
    localparam int BTN_R     = 5;
    localparam int BTN_START = 6;
    localparam int BTN_UP    = 8;
    localparam int BTN_DOWN  = 9;
    localparam int BTN_LEFT  = 10;
    localparam int BTN_RIGHT = 11;

    // configuration register indexes
    localparam logic [1:0] CFG_MAP_NORMAL  = 2'd0;
    localparam logic [1:0] CFG_MAP_SWAPPED = 2'd1;
    localparam logic [1:0] CFG_HOLD_TICKS  = 2'd2;

    // input item
    typedef struct packed {
        logic        command;
        logic [11:0] buttons;
    } in_t;

    // result item
    typedef struct packed {
        logic [13:0] button_bits;
        logic [3:0]  hat;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic [7:0]  stick_z;
        logic [7:0]  stick_rz;
        logic        swap_state;
        logic [1:0]  dpad_state;
    } out_t;

    // controls of one hold counter
    typedef struct packed {
        logic held;
        logic counting;
        logic tick;
        logic advance;
    } hold_ctl_t;

endpackage

// ----- sv/gre_hold.sv -----
// hold counter for one button combo with wait-for-release
module gre_hold (
    input  logic                aclk,
    input  logic                aresetn,
    input  gre_pkg::hold_ctl_t  ctl,
    input  logic [7:0]          hold_ticks,
    output logic                fire
);

    logic [7:0] count_reg, count_next;
    logic       wait_reg, wait_next;
    logic [7:0] count_inc;

    assign count_inc = count_reg + 8'd1;

    // next counter and wait flag
    always_comb begin
        count_next = count_reg;
        wait_next  = wait_reg;
        fire       = 1'b0;
        if (!ctl.held) begin
            count_next = 8'd0;
            wait_next  = 1'b0;
        end else if (!ctl.counting || wait_reg) begin
            count_next = 8'd0;
        end else if (ctl.tick) begin
            if (count_inc >= hold_ticks) begin
                count_next = 8'd0;
                wait_next  = 1'b1;
                fire       = 1'b1;
            end else begin
                count_next = count_inc;
            end
        end
    end

    // state moves only when an item is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 8'd0;
            wait_reg  <= 1'b0;
        end else if (ctl.advance) begin
            count_reg <= count_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

// ----- sv/gre_report.sv -----
// report encoder: button remap and d-pad formatting
module gre_report #(
    parameter int PHYS_BUTTONS = gre_pkg::PHYS_BUTTONS
) (
    input  logic [11:0]             buttons,
    input  logic [4*PHYS_BUTTONS-1:0] map,
    input  logic                    swap_mode,
    input  logic [1:0]              dpad_mode,
    output gre_pkg::out_t           report
);

    logic [13:0] bits;
    logic [3:0]  usage [PHYS_BUTTONS];
    logic        up, down, left, right;

    assign up    = buttons[gre_pkg::BTN_UP];
    assign down  = buttons[gre_pkg::BTN_DOWN];
    assign left  = buttons[gre_pkg::BTN_LEFT];
    assign right = buttons[gre_pkg::BTN_RIGHT];

    // remap pressed buttons through the usage nibbles
    always_comb begin
        bits = 14'd0;
        for (int i = 0; i < PHYS_BUTTONS; i++) begin
            usage[i] = map[4*i +: 4];
            if (buttons[i] && usage[i] != gre_pkg::USAGE_NONE
                    && usage[i] != gre_pkg::USAGE_VOID) begin
                bits = bits | (14'd1 << (usage[i] - 4'd1));
            end
        end
    end

    // d-pad formatting by mode
    always_comb begin
        report.button_bits = bits;
        report.hat         = gre_pkg::HAT_NONE;
        report.stick_x     = gre_pkg::STICK_CENTER;
        report.stick_y     = gre_pkg::STICK_CENTER;
        report.stick_z     = gre_pkg::STICK_CENTER;
        report.stick_rz    = gre_pkg::STICK_CENTER;
        report.swap_state  = swap_mode;
        report.dpad_state  = dpad_mode;
        unique case (dpad_mode)
            gre_pkg::DPAD_ANALOG: begin
                if (left) begin
                    report.stick_x = gre_pkg::STICK_LOW;
                end else if (right) begin
                    report.stick_x = gre_pkg::STICK_HIGH;
                end
                if (up) begin
                    report.stick_y = gre_pkg::STICK_LOW;
                end else if (down) begin
                    report.stick_y = gre_pkg::STICK_HIGH;
                end
            end
            gre_pkg::DPAD_HAT: begin
                // diagonals first, then the four straight directions
                if (up && left) begin
                    report.hat = gre_pkg::HAT_NW;
                end else if (up && right) begin
                    report.hat = gre_pkg::HAT_NE;
                end else if (down && left) begin
                    report.hat = gre_pkg::HAT_SW;
                end else if (down && right) begin
                    report.hat = gre_pkg::HAT_SE;
                end else if (up) begin
                    report.hat = gre_pkg::HAT_N;
                end else if (right) begin
                    report.hat = gre_pkg::HAT_E;
                end else if (down) begin
                    report.hat = gre_pkg::HAT_S;
                end else if (left) begin
                    report.hat = gre_pkg::HAT_W;
                end
            end
            gre_pkg::DPAD_ZRZ: begin
                if (left) begin
                    report.stick_z = gre_pkg::STICK_LOW;
                end else if (right) begin
                    report.stick_z = gre_pkg::STICK_HIGH;
                end
                if (up) begin
                    report.stick_rz = gre_pkg::STICK_LOW;
                end else if (down) begin
                    report.stick_rz = gre_pkg::STICK_HIGH;
                end
            end
            default: begin
                // unused mode code: everything centered, no hat
            end
        endcase
    end

endmodule

// ----- sv/gamepad_report_encoder_top.sv -----
// top level of the gamepad report encoder
//
// s_ channel takes one item per cycle: a button sample, optionally with a
// timer tick. Every item gives exactly one report item on the m_ channel.
// Both channels use valid/ready; an item moves on a clock edge with both high.
// cfg_we/cfg_index/cfg_wdata write map_normal (0), map_swapped (1) and
// hold_ticks (2) with no wait; write only while the block is idle.
// An item waits in the input register, where the hold counters and modes are
// updated and the report is formed, then lands in the output register, which
// drives m_valid. Throughput is one item per cycle while m_ready stays high;
// the input register takes a new item in the same cycle the output register
// is unloaded. When the receiver stalls, the output register holds its report
// and the input register holds one more item; s_ready then drops.
// Synchronous active-low reset clears the modes, hold counters, wait flags
// and valid flags, and sets both maps and hold_ticks to their defaults.
module gamepad_report_encoder_top #(
    parameter int PHYS_BUTTONS = gre_pkg::PHYS_BUTTONS
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gre_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output gre_pkg::out_t  m_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wdata
);

    localparam int MAP_W = 4 * PHYS_BUTTONS;

    logic [MAP_W-1:0]   map_normal_reg;
    logic [MAP_W-1:0]   map_swapped_reg;
    logic [7:0]         hold_ticks_reg;

    gre_pkg::in_t       in_reg;
    logic               in_valid_reg;
    gre_pkg::out_t      out_reg;
    logic               out_valid_reg;

    logic               swap_mode_reg, swap_mode_next;
    logic [1:0]         dpad_mode_reg, dpad_mode_next;

    logic               advance;
    logic               start, swap_combo, dpad_combo;
    logic               swap_fire, dpad_fire;
    gre_pkg::hold_ctl_t swap_ctl, dpad_ctl;
    gre_pkg::out_t      report;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_normal_reg  <= gre_pkg::MAP_RESET[MAP_W-1:0];
            map_swapped_reg <= gre_pkg::MAP_RESET[MAP_W-1:0];
            hold_ticks_reg  <= gre_pkg::HOLD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gre_pkg::CFG_MAP_NORMAL:  map_normal_reg  <= cfg_wdata[MAP_W-1:0];
                gre_pkg::CFG_MAP_SWAPPED: map_swapped_reg <= cfg_wdata[MAP_W-1:0];
                gre_pkg::CFG_HOLD_TICKS:  hold_ticks_reg  <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // handshake: the input register moves on when the output slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // combo decode
    assign start      = in_reg.buttons[gre_pkg::BTN_START];
    assign swap_combo = start && in_reg.buttons[gre_pkg::BTN_R];
    assign dpad_combo = start && in_reg.buttons[gre_pkg::BTN_L];

    assign swap_ctl = '{held: swap_combo, counting: 1'b1,
                        tick: in_reg.command, advance: advance};
    assign dpad_ctl = '{held: dpad_combo, counting: !swap_combo,
                        tick: in_reg.command, advance: advance};

    gre_hold u_swap_hold (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (swap_ctl),
        .hold_ticks (hold_ticks_reg),
        .fire       (swap_fire)
    );

    gre_hold u_dpad_hold (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (dpad_ctl),
        .hold_ticks (hold_ticks_reg),
        .fire       (dpad_fire)
    );

    // mode updates
    always_comb begin
        swap_mode_next = swap_mode_reg ^ swap_fire;
        dpad_mode_next = dpad_mode_reg;
        if (dpad_fire) begin
            dpad_mode_next = (dpad_mode_reg >= gre_pkg::DPAD_ZRZ) ?
                             gre_pkg::DPAD_ANALOG : dpad_mode_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_mode_reg <= 1'b0;
            dpad_mode_reg <= gre_pkg::DPAD_ANALOG;
        end else if (advance) begin
            swap_mode_reg <= swap_mode_next;
            dpad_mode_reg <= dpad_mode_next;
        end
    end

    // report from the updated modes
    gre_report #(
        .PHYS_BUTTONS (PHYS_BUTTONS)
    ) u_report (
        .buttons   (in_reg.buttons),
        .map       (swap_mode_next ? map_swapped_reg : map_normal_reg),
        .swap_mode (swap_mode_next),
        .dpad_mode (dpad_mode_next),
        .report    (report)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= report;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ----- tb/sv/gre_report_scoreboard_pkg.sv -----
// report predictor and scoreboard for the gamepad report encoder testbench
package gre_report_scoreboard_pkg;

    import gre_pkg::*;

    class report_scoreboard;

        // register copies
        logic [31:0] map_normal;
        logic [31:0] map_swapped;
        logic [7:0]  hold_ticks;

        // mode and hold state
        bit          swap_mode;
        logic [1:0]  dpad_mode;
        logic [7:0]  swap_count;
        logic [7:0]  dpad_count;
        bit          swap_wait;
        bit          dpad_wait;

        // reports still owed by the block, oldest first
        out_t        report_queue[$];

        int unsigned n_checked;
        int unsigned n_errors;
        int unsigned n_swaps;
        int unsigned n_dpad_turns;

        function new();
            map_normal   = MAP_RESET;
            map_swapped  = MAP_RESET;
            hold_ticks   = HOLD_RESET;
            swap_mode    = 1'b0;
            dpad_mode    = DPAD_ANALOG;
            swap_count   = '0;
            dpad_count   = '0;
            swap_wait    = 1'b0;
            dpad_wait    = 1'b0;
            n_checked    = 0;
            n_errors     = 0;
            n_swaps      = 0;
            n_dpad_turns = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                CFG_MAP_NORMAL:  map_normal  = value;
                CFG_MAP_SWAPPED: map_swapped = value;
                CFG_HOLD_TICKS:  hold_ticks  = value[7:0];
                default: ;
            endcase
        endfunction

        // one hold counter step, returns 1 when the mode must change
        function bit hold_advance(bit held, bit counting, bit tick,
                                  inout logic [7:0] count, inout bit waiting);
            if (!held) begin
                count   = '0;
                waiting = 1'b0;
                return 1'b0;
            end
            if (!counting || waiting) begin
                count = '0;
                return 1'b0;
            end
            if (tick) begin
                count = count + 8'd1;
                if (count >= hold_ticks) begin
                    count   = '0;
                    waiting = 1'b1;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function int pending();
            return report_queue.size();
        endfunction

        // accepted sample: update modes, then form the report it gives
        function void note_sample(in_t it);
            logic [11:0] b;
            logic [31:0] map;
            logic [3:0]  usage;
            bit          tick, start, swap_combo, dpad_combo;
            bit          up, down, left, right;
            out_t        rep;
            b          = it.buttons;
            tick       = it.command;
            start      = b[BTN_START];
            swap_combo = start && b[BTN_R];
            dpad_combo = start && b[BTN_L];
            up         = b[BTN_UP];
            down       = b[BTN_DOWN];
            left       = b[BTN_LEFT];
            right      = b[BTN_RIGHT];

            // start+r wins over start+l
            if (hold_advance(swap_combo, 1'b1, tick, swap_count, swap_wait)) begin
                swap_mode = !swap_mode;
                n_swaps++;
            end
            if (hold_advance(dpad_combo, !swap_combo, tick, dpad_count, dpad_wait)) begin
                dpad_mode = (dpad_mode >= DPAD_ZRZ) ? DPAD_ANALOG : dpad_mode + 2'd1;
                n_dpad_turns++;
            end

            rep.button_bits = '0;
            rep.hat         = HAT_NONE;
            rep.stick_x     = STICK_CENTER;
            rep.stick_y     = STICK_CENTER;
            rep.stick_z     = STICK_CENTER;
            rep.stick_rz    = STICK_CENTER;

            // usage remap, none and void usages dropped
            map = swap_mode ? map_swapped : map_normal;
            for (int i = 0; i < PHYS_BUTTONS; i++) begin
                usage = map[4*i +: 4];
                if (b[i] && usage != USAGE_NONE && usage != USAGE_VOID)
                    rep.button_bits[int'(usage) - 1] = 1'b1;
            end

            // d-pad encoding per mode
            case (dpad_mode)
                DPAD_ANALOG: begin
                    if (left)       rep.stick_x = STICK_LOW;
                    else if (right) rep.stick_x = STICK_HIGH;
                    if (up)         rep.stick_y = STICK_LOW;
                    else if (down)  rep.stick_y = STICK_HIGH;
                end
                DPAD_HAT: begin
                    if (up && left)        rep.hat = HAT_NW;
                    else if (up && right)  rep.hat = HAT_NE;
                    else if (down && left) rep.hat = HAT_SW;
                    else if (down && right) rep.hat = HAT_SE;
                    else if (up)           rep.hat = HAT_N;
                    else if (right)        rep.hat = HAT_E;
                    else if (down)         rep.hat = HAT_S;
                    else if (left)         rep.hat = HAT_W;
                end
                DPAD_ZRZ: begin
                    if (left)       rep.stick_z = STICK_LOW;
                    else if (right) rep.stick_z = STICK_HIGH;
                    if (up)         rep.stick_rz = STICK_LOW;
                    else if (down)  rep.stick_rz = STICK_HIGH;
                end
                default: ;
            endcase

            rep.swap_state = swap_mode;
            rep.dpad_state = dpad_mode;
            report_queue.push_back(rep);
        endfunction

        // compare one report from the block with the oldest owed one
        function void check_report(out_t got);
            out_t exp;
            bit   bad;
            if (report_queue.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected report: bits=%h hat=%0d x=%0d y=%0d z=%0d rz=%0d",
                             got.button_bits, got.hat, got.stick_x, got.stick_y,
                             got.stick_z, got.stick_rz);
                return;
            end
            exp = report_queue.pop_front();
            n_checked++;
            bad = (got.button_bits !== exp.button_bits) || (got.hat !== exp.hat) ||
                  (got.stick_x !== exp.stick_x) || (got.stick_y !== exp.stick_y) ||
                  (got.stick_z !== exp.stick_z) || (got.stick_rz !== exp.stick_rz) ||
                  (got.swap_state !== exp.swap_state) ||
                  (got.dpad_state !== exp.dpad_state);
            if (bad) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("report %0d mismatch", n_checked);
                    $display("  exp bits=%h hat=%0d x=%0d y=%0d z=%0d rz=%0d swap=%0d dpad=%0d",
                             exp.button_bits, exp.hat, exp.stick_x, exp.stick_y,
                             exp.stick_z, exp.stick_rz, exp.swap_state, exp.dpad_state);
                    $display("  got bits=%h hat=%0d x=%0d y=%0d z=%0d rz=%0d swap=%0d dpad=%0d",
                             got.button_bits, got.hat, got.stick_x, got.stick_y,
                             got.stick_z, got.stick_rz, got.swap_state, got.dpad_state);
                end
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/gamepad_report_encoder_top_tb.sv -----
// testbench top of the gamepad report encoder: stimulus, handshakes and checking
module gamepad_report_encoder_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import gre_pkg::*;
    import gre_report_scoreboard_pkg::*;

    // button masks
    localparam logic [11:0] M_L     = 12'(1) << BTN_L;
    localparam logic [11:0] M_R     = 12'(1) << BTN_R;
    localparam logic [11:0] M_START = 12'(1) << BTN_START;
    localparam logic [11:0] M_UP    = 12'(1) << BTN_UP;
    localparam logic [11:0] M_DOWN  = 12'(1) << BTN_DOWN;
    localparam logic [11:0] M_LEFT  = 12'(1) << BTN_LEFT;
    localparam logic [11:0] M_RIGHT = 12'(1) << BTN_RIGHT;
    localparam logic [11:0] M_FACE  = 12'h0FF;

    // kinds of combo hold sequence
    localparam int HOLD_SWAP = 0;
    localparam int HOLD_DPAD = 1;
    localparam int HOLD_BOTH = 2;

    localparam int RANDOM_PHASES = 8;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_t         s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_t        m_data;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_MAP_NORMAL;
    logic [31:0] cfg_wdata = '0;

    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned n_sent    = 0;
    int unsigned n_phases  = 0;

    report_scoreboard sb = new();

    gamepad_report_encoder_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offer one item, with a random gap in front, and hold it until taken
    task automatic send_item(input logic cmd, input logic [11:0] buttons);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= '{command: cmd, buttons: buttons};
        do @(posedge aclk); while (!s_ready);
        sb.note_sample('{command: cmd, buttons: buttons});
        n_sent++;
    endtask

    // stop sending and let every owed report come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write all three registers while the block is idle
    task automatic write_config(input logic [31:0] mn, input logic [31:0] ms,
                                input logic [7:0] ht);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAP_NORMAL;
        cfg_wdata <= mn;
        @(posedge aclk);
        sb.write_reg(CFG_MAP_NORMAL, mn);
        cfg_index <= CFG_MAP_SWAPPED;
        cfg_wdata <= ms;
        @(posedge aclk);
        sb.write_reg(CFG_MAP_SWAPPED, ms);
        cfg_index <= CFG_HOLD_TICKS;
        cfg_wdata <= {24'd0, ht};
        @(posedge aclk);
        sb.write_reg(CFG_HOLD_TICKS, {24'd0, ht});
        cfg_we    <= 1'b0;
        n_phases++;
    endtask

    // hold a combo for len items with mostly ticks, then let go
    task automatic run_hold(input int kind, input int len);
        logic [11:0] b;
        int          n_rel;
        for (int i = 0; i < len; i++) begin
            b = 12'($urandom) | M_START;
            case (kind)
                HOLD_SWAP: b = b | M_R;
                HOLD_DPAD: b = (b | M_L) & ~M_R;
                default:   b = b | M_R | M_L;
            endcase
            send_item($urandom_range(99) < 85, b);
        end
        // release by dropping start, or by dropping both shoulder buttons
        n_rel = $urandom_range(1, 3);
        for (int i = 0; i < n_rel; i++) begin
            b = 12'($urandom);
            if ($urandom_range(1))
                b = b & ~M_START;
            else
                b = b & ~(M_L | M_R);
            send_item(1'($urandom_range(1)), b);
        end
    endtask

    // report handshake with random stalls
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready)
                sb.check_report(m_data);
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // hard limit on the run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          budget;
        int          phase_start;
        int          r;
        int          hold;
        logic [31:0] mn;
        logic [31:0] ms;
        logic [7:0]  ht;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, idle free
        send_item(1'b0, 12'h000);
        send_item(1'b0, M_FACE);                  // both combos, no tick
        send_item(1'b1, 12'hFFF);                 // both combos with tick
        send_item(1'b0, M_UP);
        send_item(1'b0, M_DOWN);
        send_item(1'b0, M_LEFT);
        send_item(1'b0, M_RIGHT);
        send_item(1'b0, M_UP | M_DOWN);           // up wins
        send_item(1'b0, M_LEFT | M_RIGHT);        // left wins

        // usages none and void in the maps, zero hold ticks
        write_config(32'h0ED3_C2BF, 32'h1234_5678, 8'd0);
        send_item(1'b0, M_FACE);
        send_item(1'b1, M_START | M_R);           // first tick toggles swap
        send_item(1'b1, M_START | M_R | M_FACE);  // waiting for release
        send_item(1'b0, 12'h000);
        send_item(1'b1, M_START | M_L);           // to hat mode
        send_item(1'b0, M_UP);
        send_item(1'b0, M_UP | M_RIGHT);
        send_item(1'b0, M_RIGHT);
        send_item(1'b0, M_DOWN | M_RIGHT);
        send_item(1'b0, M_DOWN);
        send_item(1'b0, M_DOWN | M_LEFT);
        send_item(1'b0, M_LEFT);
        send_item(1'b0, M_UP | M_LEFT | M_DOWN | M_RIGHT);
        send_item(1'b1, M_START | M_L);           // to z/rz mode
        send_item(1'b0, M_UP | M_LEFT | M_DOWN | M_RIGHT);
        send_item(1'b0, M_DOWN | M_RIGHT);
        send_item(1'b0, 12'h000);
        send_item(1'b1, M_START | M_L);           // back to analog

        // random phases over settings and idle patterns
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            mn = $urandom;
            ms = $urandom;
            ht = 8'($urandom_range(1, 12));
            budget = 90;
            case (phase)
                0: ht = 8'd1;
                1: ht = 8'd4;
                2: begin
                    ht = 8'd255;
                    mn = 32'h0000_0000;
                    ms = 32'hFFFF_FFFF;
                    budget = 150;
                end
                3: ht = 8'd2;
                5: begin
                    mn = 32'hFFFF_FFFF;
                    ms = 32'h0000_0000;
                end
                default: ;
            endcase
            write_config(mn, ms, ht);
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 46; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 46; end
                default: begin gap_pct = 12; stall_pct = 12; end
            endcase
            hold = int'(ht);
            phase_start = n_sent;
            while (n_sent - phase_start < budget) begin
                r = $urandom_range(99);
                if (r < 25)
                    send_item(1'($urandom_range(1)), 12'($urandom));
                else if (r < 85)
                    run_hold($urandom_range(HOLD_BOTH),
                             hold + hold / 4 + $urandom_range(1, 4));
                else
                    run_hold($urandom_range(HOLD_BOTH), $urandom_range(1, hold));
                // sender holds off until the block has drained
                if ($urandom_range(39) == 0)
                    wait_idle();
            end
        end

        // drain
        wait_idle();
        repeat (8) @(posedge aclk);

        $display("sent %0d items over %0d register settings, %0d reports checked",
                 n_sent, n_phases + 1, sb.n_checked);
        $display("swap toggles %0d, d-pad mode changes %0d, mismatches %0d",
                 sb.n_swaps, sb.n_dpad_turns, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
